/* rtl/sbdm_pkg.sv */
// shared types, register codes and constants for the drive mixer
`timescale 1ns / 1ps
`default_nettype none

package sbdm_pkg;

    localparam int DEF_HOLDOFF_TICKS  = 200;
    localparam int DEF_INTEGRAL_LIMIT = 25600;
    localparam int SEP_THRESHOLD      = 2560;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_P_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_D_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_P_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_I_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_P_GAIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_D_GAIN    = 3'd7;

    typedef struct packed {
        logic signed [15:0] tilt_angle;
        logic signed [15:0] tilt_rate;
        logic signed [15:0] wheel_speed;
        logic signed [15:0] line_offset;
    } sbdm_in_t;

    typedef struct packed {
        logic signed [31:0] left_drive;
        logic signed [31:0] right_drive;
    } sbdm_out_t;

    typedef struct packed {
        logic signed [15:0] target_angle;
        logic signed [15:0] target_speed;
        logic [15:0]        balance_p_gain;
        logic [15:0]        balance_d_gain;
        logic [15:0]        speed_p_gain;
        logic [15:0]        speed_i_gain;
        logic [15:0]        turn_p_gain;
        logic [15:0]        turn_d_gain;
    } sbdm_cfg_t;

    localparam sbdm_cfg_t CFG_RESET = '{
        target_angle:   16'sd384,
        target_speed:   16'sd2560,
        balance_p_gain: 16'd17600,
        balance_d_gain: 16'd288,
        speed_p_gain:   16'd160,
        speed_i_gain:   16'd32,
        turn_p_gain:    16'd240,
        turn_d_gain:    16'd1920
    };

    // gain products, 12 fraction bits
    typedef struct packed {
        logic signed [33:0] bal_p;
        logic signed [33:0] bal_d;
        logic signed [33:0] spd_p;
        logic signed [33:0] spd_i;
        logic signed [33:0] trn_p;
        logic signed [33:0] trn_d;
    } sbdm_prod_t;

endpackage

`default_nettype wire

/* rtl/sbdm_terms.sv */
// error terms, controller state and the six gain products of one tick
`timescale 1ns / 1ps
`default_nettype none

module sbdm_terms
    import sbdm_pkg::*;
#(
    parameter int HOLDOFF_TICKS  = DEF_HOLDOFF_TICKS,
    parameter int INTEGRAL_LIMIT = DEF_INTEGRAL_LIMIT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire sbdm_in_t   item,
    input  wire sbdm_cfg_t  cfg,
    output sbdm_prod_t      prod
);

    localparam logic signed [16:0] SEP_HI = 17'(SEP_THRESHOLD);
    localparam logic signed [16:0] SEP_LO = -17'(SEP_THRESHOLD);
    localparam logic signed [17:0] LIM_HI = 18'(INTEGRAL_LIMIT);
    localparam logic signed [17:0] LIM_LO = -18'(INTEGRAL_LIMIT);
    localparam logic [7:0]         HOLDOFF = 8'(HOLDOFF_TICKS);

    logic signed [15:0] integral_reg;
    logic signed [15:0] integral_next;
    logic signed [15:0] prev_offset_reg;
    logic [7:0]         startup_reg;

    logic signed [16:0] angle_err;
    logic signed [16:0] speed_err;
    logic signed [16:0] offset_diff;
    logic signed [17:0] acc;
    logic               in_sep;
    logic               hold;

    assign angle_err   = 17'(item.tilt_angle) - 17'(cfg.target_angle);
    assign speed_err   = 17'(cfg.target_speed) - 17'(item.wheel_speed);
    assign offset_diff = 17'(prev_offset_reg) - 17'(item.line_offset);
    assign in_sep      = (speed_err <= SEP_HI) && (speed_err >= SEP_LO);
    assign hold        = startup_reg < HOLDOFF;
    assign acc         = 18'(integral_reg) + 18'(speed_err);

    always_comb
    begin
        integral_next = integral_reg;
        if (in_sep)
        begin
            if (acc > LIM_HI)
                integral_next = LIM_HI[15:0];
            else if (acc < LIM_LO)
                integral_next = LIM_LO[15:0];
            else
                integral_next = acc[15:0];
        end
    end

    always_comb
    begin
        prod.bal_p = $signed({1'b0, cfg.balance_p_gain}) * angle_err;
        prod.bal_d = $signed({1'b0, cfg.balance_d_gain}) * 17'(item.tilt_rate);
        prod.spd_p = '0;
        prod.spd_i = '0;
        prod.trn_p = '0;
        prod.trn_d = '0;
        if (!hold)
        begin
            prod.spd_p = $signed({1'b0, cfg.speed_p_gain}) * speed_err;
            if (in_sep)
                prod.spd_i = $signed({1'b0, cfg.speed_i_gain}) * 17'(integral_next);
            prod.trn_p = $signed({1'b0, cfg.turn_p_gain}) * 17'(item.line_offset);
            prod.trn_d = $signed({1'b0, cfg.turn_d_gain}) * offset_diff;
        end
    end

    // integral keeps running through the holdoff window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg    <= '0;
            prev_offset_reg <= '0;
            startup_reg     <= '0;
        end
        else if (advance)
        begin
            integral_reg    <= integral_next;
            prev_offset_reg <= item.line_offset;
            if (hold)
                startup_reg <= startup_reg + 8'd1;
        end
    end

endmodule

`default_nettype wire

/* rtl/sbdm_mix.sv */
// sums the products into left and right drive, floors to q24.8 and saturates
`timescale 1ns / 1ps
`default_nettype none

module sbdm_mix
    import sbdm_pkg::*;
(
    input  wire sbdm_prod_t prod,
    output sbdm_out_t       result
);

    localparam logic signed [37:0] OUT_MAX = 38'sd2147483647;
    localparam logic signed [37:0] OUT_MIN = -38'sd2147483648;

    logic signed [37:0] common;
    logic signed [37:0] turn;
    logic signed [37:0] left_sum;
    logic signed [37:0] right_sum;
    logic signed [37:0] left_q;
    logic signed [37:0] right_q;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > OUT_MAX)
            r = OUT_MAX[31:0];
        else if (v < OUT_MIN)
            r = OUT_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    assign common    = 38'(prod.bal_p) + 38'(prod.bal_d) - 38'(prod.spd_p) - 38'(prod.spd_i);
    assign turn      = 38'(prod.trn_p) + 38'(prod.trn_d);
    assign left_sum  = common + turn;
    assign right_sum = common - turn;

    // arithmetic shift rounds toward minus infinity
    assign left_q  = left_sum >>> 4;
    assign right_q = right_sum >>> 4;

    assign result.left_drive  = sat32(left_q);
    assign result.right_drive = sat32(right_q);

endmodule

`default_nettype wire

/* rtl/self_balancing_drive_mixer.sv */
// top level of the self-balancing drive mixer
// Usage:
//   One input transfer is one control tick: tilt angle, tilt rate, wheel speed
//   and line offset in signed q8.8. One output transfer per tick carries the
//   left and right motor commands, saturated to signed 32 bits.
//   Both channels use valid/stall; a transfer happens when valid is high and
//   stall is low. Gains and setpoints are written through cfg_we/cfg_index/
//   cfg_data while no tick is in flight.
//   out_valid rises once the tick has passed the input register, product
//   register and result register, and the output transfer follows when stall
//   is low. Throughput is one tick per cycle while the receiver does not stall; the
//   integral, previous offset and startup count update in the product stage
//   as the tick enters it, so each tick sees the state left by the one before it.
//   Reset loads the default gains and setpoints, clears the integral, previous
//   offset and startup count, and empties the pipeline.
//   When the receiver stalls, the result register holds its transfer and the
//   stages behind it fill up; in_stall rises once all three are occupied.
`timescale 1ns / 1ps
`default_nettype none

module self_balancing_drive_mixer
    import sbdm_pkg::*;
#(
    parameter int HOLDOFF_TICKS  = DEF_HOLDOFF_TICKS,
    parameter int INTEGRAL_LIMIT = DEF_INTEGRAL_LIMIT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire sbdm_in_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output sbdm_out_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    sbdm_cfg_t  cfg_reg;
    sbdm_in_t   item_reg;
    logic       item_valid_reg;
    sbdm_prod_t prod_reg;
    sbdm_prod_t prod_next;
    logic       prod_valid_reg;
    sbdm_out_t  out_reg;
    sbdm_out_t  out_next;
    logic       out_valid_reg;

    logic out_free;
    logic prod_free;
    logic item_free;
    logic item_adv;
    logic prod_adv;
    logic in_xfer;

    assign out_free  = !out_valid_reg || !out_stall;
    assign prod_adv  = prod_valid_reg && out_free;
    assign prod_free = !prod_valid_reg || out_free;
    assign item_adv  = item_valid_reg && prod_free;
    assign item_free = !item_valid_reg || prod_free;
    assign in_stall  = !item_free;
    assign in_xfer   = in_valid && item_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_ANGLE:   cfg_reg.target_angle   <= cfg_data;
                REG_TARGET_SPEED:   cfg_reg.target_speed   <= cfg_data;
                REG_BALANCE_P_GAIN: cfg_reg.balance_p_gain <= cfg_data;
                REG_BALANCE_D_GAIN: cfg_reg.balance_d_gain <= cfg_data;
                REG_SPEED_P_GAIN:   cfg_reg.speed_p_gain   <= cfg_data;
                REG_SPEED_I_GAIN:   cfg_reg.speed_i_gain   <= cfg_data;
                REG_TURN_P_GAIN:    cfg_reg.turn_p_gain    <= cfg_data;
                REG_TURN_D_GAIN:    cfg_reg.turn_d_gain    <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    sbdm_terms #(
        .HOLDOFF_TICKS  (HOLDOFF_TICKS),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_terms (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (item_adv),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .prod    (prod_next)
    );

    sbdm_mix u_mix (
        .prod   (prod_reg),
        .result (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_free)
                item_valid_reg <= in_valid;
            if (prod_free)
                prod_valid_reg <= item_valid_reg;
            if (out_free)
                out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= in_data;
        if (item_adv)
            prod_reg <= prod_next;
        if (prod_adv)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

/* sim/testbench.sv */
// drive mixer testbench: a directed tick table, then random ticks checked against a local mixer model
`timescale 1ns / 1ps

module testbench;
    import sbdm_pkg::*;

    localparam int     STALL_LIMIT = 2000;
    localparam longint DRIVE_MAX   = 64'sd2147483647;
    localparam longint DRIVE_MIN   = -64'sd2147483648;

    typedef struct {
        sbdm_in_t tick;
        bit       typed;
        int       drive;
    } tick_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    sbdm_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    sbdm_out_t out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // mixer model state and its copy of the registers
    sbdm_cfg_t gains;
    int        integ_acc;
    int        last_offset;
    int        ticks_seen;

    sbdm_out_t pending_drives[$];
    tick_row_t directed_rows[$];
    sbdm_cfg_t settings[5];
    int        fail_count;
    int        idle_cycles;
    int        no_gap_left;
    int        integ_bias;
    int        walk_offset;

    self_balancing_drive_mixer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [31:0] clip32(longint v);
        if (v > DRIVE_MAX)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < DRIVE_MIN)
        begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // one control tick of the mixer, state updated as the block does
    function automatic sbdm_out_t mix_tick(sbdm_in_t t);
        longint    bal;
        longint    spd;
        longint    trn;
        int        serr;
        int        acc;
        sbdm_out_t res;
        bal = longint'(gains.balance_p_gain)
              * (longint'(t.tilt_angle) - longint'(gains.target_angle))
            + longint'(gains.balance_d_gain) * longint'(t.tilt_rate);
        serr = int'(gains.target_speed) - int'(t.wheel_speed);
        spd = longint'(gains.speed_p_gain) * longint'(serr);
        // integral separation: only small errors feed the integral
        if (serr <= SEP_THRESHOLD && serr >= -SEP_THRESHOLD)
        begin
            acc = integ_acc + serr;
            if (acc > DEF_INTEGRAL_LIMIT)
            begin
                acc = DEF_INTEGRAL_LIMIT;
            end
            if (acc < -DEF_INTEGRAL_LIMIT)
            begin
                acc = -DEF_INTEGRAL_LIMIT;
            end
            integ_acc = acc;
            spd = spd + longint'(gains.speed_i_gain) * longint'(integ_acc);
        end
        trn = longint'(gains.turn_p_gain) * longint'(t.line_offset)
            + longint'(gains.turn_d_gain) * (longint'(last_offset) - longint'(t.line_offset));
        last_offset = int'(t.line_offset);
        if (ticks_seen < DEF_HOLDOFF_TICKS)
        begin
            ticks_seen = ticks_seen + 1;
            spd = 0;
            trn = 0;
        end
        res.left_drive  = clip32((bal - spd + trn) >>> 4);
        res.right_drive = clip32((bal - spd - trn) >>> 4);
        return res;
    endfunction

    function automatic logic signed [15:0] around(int base, int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
        begin
            v = 32767;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] extreme16();
        return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endfunction

    function automatic sbdm_in_t random_tick();
        sbdm_in_t t;
        int       err;
        int       ws;
        if ($urandom_range(0, 63) == 0)
        begin
            integ_bias = int'($urandom_range(0, 2)) - 1;
        end
        case ($urandom_range(0, 9))
            0:       t.tilt_angle = extreme16();
            1, 2, 3: t.tilt_angle = 16'($urandom);
            default: t.tilt_angle = around(int'(gains.target_angle), 512);
        endcase
        case ($urandom_range(0, 9))
            0:          t.tilt_rate = extreme16();
            1, 2, 3, 4: t.tilt_rate = 16'($urandom);
            default:    t.tilt_rate = around(0, 2048);
        endcase
        // zero speed error unless one of the arms below picks another
        t.wheel_speed = gains.target_speed;
        // speed error mostly inside the separation band, biased in runs so the integral clamps
        case ($urandom_range(0, 19))
            0:
            begin
                err = 0;
                t.wheel_speed = extreme16();
            end
            1, 2, 3:
            begin
                err = 0;
                t.wheel_speed = 16'($urandom);
            end
            4, 5:
            begin
                case ($urandom_range(0, 3))
                    0:       err = SEP_THRESHOLD;
                    1:       err = -SEP_THRESHOLD;
                    2:       err = SEP_THRESHOLD + 1;
                    default: err = -SEP_THRESHOLD - 1;
                endcase
            end
            default:
            begin
                err = int'($urandom_range(0, SEP_THRESHOLD));
                if (integ_bias < 0 || (integ_bias == 0 && $urandom_range(0, 1) == 0))
                begin
                    err = -err;
                end
            end
        endcase
        if (err != 0)
        begin
            ws = int'(gains.target_speed) - err;
            t.wheel_speed = (ws > 32767 || ws < -32768) ? 16'($urandom) : 16'(ws);
        end
        case ($urandom_range(0, 9))
            0:       t.line_offset = extreme16();
            1, 2, 3: t.line_offset = 16'($urandom);
            default: t.line_offset = around(walk_offset, 1024);
        endcase
        walk_offset = int'(t.line_offset);
        return t;
    endfunction

    function automatic int tick_gap();
        int r;
        if (no_gap_left > 0)
        begin
            no_gap_left = no_gap_left - 1;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 3)
        begin
            no_gap_left = int'($urandom_range(30, 80));
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(8, 30));
    endfunction

    task automatic add_row(int a, int r, int w, int o, bit typed, int drive);
        tick_row_t row;
        row.tick.tilt_angle  = 16'(a);
        row.tick.tilt_rate   = 16'(r);
        row.tick.wheel_speed = 16'(w);
        row.tick.line_offset = 16'(o);
        row.typed = typed;
        row.drive = drive;
        directed_rows.push_back(row);
    endtask

    task automatic send_tick(sbdm_in_t t, bit typed, int drive);
        int        gap;
        sbdm_out_t pred;
        gap = tick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (in_stall);
        pred = mix_tick(t);
        if (typed)
        begin
            pred.left_drive  = drive;
            pred.right_drive = drive;
        end
        pending_drives.push_back(pred);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_TARGET_ANGLE:   gains.target_angle   = value;
            REG_TARGET_SPEED:   gains.target_speed   = value;
            REG_BALANCE_P_GAIN: gains.balance_p_gain = value;
            REG_BALANCE_D_GAIN: gains.balance_d_gain = value;
            REG_SPEED_P_GAIN:   gains.speed_p_gain   = value;
            REG_SPEED_I_GAIN:   gains.speed_i_gain   = value;
            REG_TURN_P_GAIN:    gains.turn_p_gain    = value;
            default:            gains.turn_d_gain    = value;
        endcase
    endtask

    task automatic load_settings(sbdm_cfg_t s);
        write_reg(REG_TURN_D_GAIN,    s.turn_d_gain);
        write_reg(REG_TARGET_ANGLE,   s.target_angle);
        write_reg(REG_SPEED_I_GAIN,   s.speed_i_gain);
        write_reg(REG_TARGET_SPEED,   s.target_speed);
        write_reg(REG_BALANCE_P_GAIN, s.balance_p_gain);
        write_reg(REG_TURN_P_GAIN,    s.turn_p_gain);
        write_reg(REG_BALANCE_D_GAIN, s.balance_d_gain);
        write_reg(REG_SPEED_P_GAIN,   s.speed_p_gain);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // result checking
    always @(posedge clk)
    begin
        sbdm_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_drives.size() == 0)
            begin
                $error("unexpected transfer: left_drive %0d right_drive %0d",
                       out_data.left_drive, out_data.right_drive);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = pending_drives.pop_front();
                if (out_data.left_drive !== want.left_drive)
                begin
                    $error("left_drive: expected %0d, got %0d",
                           want.left_drive, out_data.left_drive);
                    fail_count = fail_count + 1;
                end
                if (out_data.right_drive !== want.right_drive)
                begin
                    $error("right_drive: expected %0d, got %0d",
                           want.right_drive, out_data.right_drive);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // receiver back-pressure: free runs and stall runs, mostly short
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            case ($urandom_range(0, 9))
                0:             n = int'($urandom_range(100, 200));
                1, 2:          n = int'($urandom_range(10, 60));
                default:       n = int'($urandom_range(1, 4));
            endcase
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            case ($urandom_range(0, 19))
                0:             n = int'($urandom_range(20, 40));
                1, 2, 3, 4:    n = int'($urandom_range(4, 10));
                default:       n = int'($urandom_range(1, 3));
            endcase
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        sbdm_cfg_t s;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_TARGET_ANGLE;
        cfg_data    = '0;
        gains       = CFG_RESET;
        integ_acc   = 0;
        last_offset = 0;
        ticks_seen  = 0;
        fail_count  = 0;
        no_gap_left = 0;
        integ_bias  = 0;
        walk_offset = 0;

        // during holdoff with default gains the drive is 1100 * (angle - 1.5) + 18 * rate
        add_row(384, 0, 2560, 0, 1'b1, 0);
        add_row(32767, 32767, 32767, 32767, 1'b1, 36211106);
        add_row(-32768, -32768, -32768, -32768, 1'b1, -37057024);
        add_row(400, 0, 0, 0, 1'b1, 17600);
        add_row(384, -1, -1, 0, 1'b1, -18);
        add_row(384, 0, 5120, 0, 1'b1, 0);
        add_row(384, 0, 5121, 0, 1'b1, 0);
        add_row(368, 16, 2560, -32768, 1'b1, -17312);
        add_row(0, 0, 0, 32767, 1'b1, -422400);
        add_row(-1, 1, -32768, -1, 1'b0, 0);
        add_row(21845, -21846, 21845, -21846, 1'b0, 0);
        add_row(-21846, 21845, -21846, 21845, 1'b0, 0);
        // error at the band edge on every tick drives the integral into its clamp
        repeat (12)
        begin
            add_row(384, 0, 0, 0, 1'b1, 0);
        end

        settings[0] = '{16'sh7FFF, 16'sh8000, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        settings[1] = '{16'sh8000, 16'sh7FFF, 16'h0000, 16'h0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000};
        s = '0;
        s.target_angle   = 16'(int'($urandom_range(0, 2048)) - 1024);
        s.target_speed   = 16'(int'($urandom_range(0, 2048)) - 1024);
        s.balance_p_gain = 16'($urandom_range(0, 4095));
        s.balance_d_gain = 16'($urandom_range(0, 4095));
        s.speed_p_gain   = 16'($urandom_range(0, 4095));
        s.speed_i_gain   = 16'($urandom_range(0, 4095));
        s.turn_p_gain    = 16'($urandom_range(0, 4095));
        s.turn_d_gain    = 16'($urandom_range(0, 4095));
        settings[2] = s;
        settings[3] = {$urandom, $urandom, $urandom, $urandom};
        settings[4] = '{16'sh0000, 16'sh0000, 16'h0001, 16'hFFFF,
                        16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001};

        repeat (8)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].drive);
        end
        repeat (400)
        begin
            send_tick(random_tick(), 1'b0, 0);
        end
        foreach (settings[p])
        begin
            drain();
            load_settings(settings[p]);
            repeat (260)
            begin
                send_tick(random_tick(), 1'b0, 0);
            end
        end
        drain();
        repeat (6)
        begin
            @(posedge clk);
        end

        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
